[hw/rtl/idu_pkg.sv]
`default_nettype none

package idu_pkg;

    localparam int WORD_BITS = 64;
    localparam int DATA_WIDTH_DEF = 64;

    typedef enum logic [1:0] {
        ACT_SIGNED_QUO   = 2'd0,
        ACT_SIGNED_REM   = 2'd1,
        ACT_UNSIGNED_QUO = 2'd2,
        ACT_UNSIGNED_REM = 2'd3
    } t_action;

    typedef struct packed {
        t_action                action;
        logic [WORD_BITS-1:0]   dividend;
        logic [WORD_BITS-1:0]   divisor;
    } t_div_in;

    typedef struct packed {
        logic [WORD_BITS-1:0]   answer;
        logic                   divide_by_zero;
    } t_div_out;

    // Control that travels with each beat down the pipeline.
    typedef struct packed {
        logic valid;
        logic is_rem;
        logic neg_ans;
        logic dbz;
    } t_idu_ctl;

endpackage

`default_nettype wire

[hw/rtl/idu_prep.sv]
`default_nettype none

module idu_prep #(
    parameter int DATA_WIDTH = idu_pkg::DATA_WIDTH_DEF
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_load,
    input  wire idu_pkg::t_div_in   i_operand,
    output idu_pkg::t_idu_ctl       o_ctl,
    output logic [DATA_WIDTH-1:0]   o_num,
    output logic [DATA_WIDTH-1:0]   o_den
);

    logic [DATA_WIDTH-1:0] a_raw;
    logic [DATA_WIDTH-1:0] b_raw;
    logic                  is_signed;
    logic                  a_neg;
    logic                  b_neg;
    logic                  is_rem;
    idu_pkg::t_idu_ctl     n_ctl;
    logic [DATA_WIDTH-1:0] n_num;
    logic [DATA_WIDTH-1:0] n_den;
    idu_pkg::t_idu_ctl     r_ctl;
    logic [DATA_WIDTH-1:0] r_num;
    logic [DATA_WIDTH-1:0] r_den;

    always_comb begin
        a_raw     = i_operand.dividend[DATA_WIDTH-1:0];
        b_raw     = i_operand.divisor[DATA_WIDTH-1:0];
        is_signed = (i_operand.action == idu_pkg::ACT_SIGNED_QUO) ||
                    (i_operand.action == idu_pkg::ACT_SIGNED_REM);
        is_rem    = (i_operand.action == idu_pkg::ACT_SIGNED_REM) ||
                    (i_operand.action == idu_pkg::ACT_UNSIGNED_REM);
        a_neg     = is_signed & a_raw[DATA_WIDTH-1];
        b_neg     = is_signed & b_raw[DATA_WIDTH-1];
        n_num     = a_neg ? (~a_raw + 1'b1) : a_raw;
        n_den     = b_neg ? (~b_raw + 1'b1) : b_raw;

        n_ctl.valid   = i_load;
        n_ctl.is_rem  = is_rem;
        // A remainder follows the dividend's sign; a quotient is negative when signs differ.
        n_ctl.neg_ans = is_rem ? a_neg : (a_neg ^ b_neg);
        n_ctl.dbz     = (b_raw == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else begin
            r_ctl <= n_ctl;
        end
        r_num <= n_num;
        r_den <= n_den;
    end

    assign o_ctl = r_ctl;
    assign o_num = r_num;
    assign o_den = r_den;

endmodule

`default_nettype wire

[hw/rtl/idu_step.sv]
`default_nettype none

module idu_step #(
    parameter int DATA_WIDTH = idu_pkg::DATA_WIDTH_DEF
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire idu_pkg::t_idu_ctl  i_ctl,
    input  wire [DATA_WIDTH-1:0]    i_rem,
    input  wire [DATA_WIDTH-1:0]    i_num,
    input  wire [DATA_WIDTH-1:0]    i_den,
    output idu_pkg::t_idu_ctl       o_ctl,
    output logic [DATA_WIDTH-1:0]   o_rem,
    output logic [DATA_WIDTH-1:0]   o_num,
    output logic [DATA_WIDTH-1:0]   o_den
);

    logic [DATA_WIDTH:0]   shifted;
    logic [DATA_WIDTH+1:0] diff;
    logic                  fits;
    logic [DATA_WIDTH-1:0] n_rem;
    logic [DATA_WIDTH-1:0] n_num;
    idu_pkg::t_idu_ctl     r_ctl;
    logic [DATA_WIDTH-1:0] r_rem;
    logic [DATA_WIDTH-1:0] r_num;
    logic [DATA_WIDTH-1:0] r_den;

    // The numerator shifts out its top bit into the remainder and takes the
    // new quotient bit at the bottom, so after all steps it holds the quotient.
    always_comb begin
        shifted = {i_rem, i_num[DATA_WIDTH-1]};
        diff    = {1'b0, shifted} - {2'b00, i_den};
        fits    = ~diff[DATA_WIDTH+1];
        n_rem   = fits ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
        n_num   = {i_num[DATA_WIDTH-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else begin
            r_ctl <= i_ctl;
        end
        r_rem <= n_rem;
        r_num <= n_num;
        r_den <= i_den;
    end

    assign o_ctl = r_ctl;
    assign o_rem = r_rem;
    assign o_num = r_num;
    assign o_den = r_den;

endmodule

`default_nettype wire

[hw/rtl/idu_fix.sv]
`default_nettype none

module idu_fix #(
    parameter int DATA_WIDTH = idu_pkg::DATA_WIDTH_DEF
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire idu_pkg::t_idu_ctl  i_ctl,
    input  wire [DATA_WIDTH-1:0]    i_rem,
    input  wire [DATA_WIDTH-1:0]    i_quo,
    output logic                    o_valid,
    output idu_pkg::t_div_out       o_result
);

    logic [DATA_WIDTH-1:0] mag;
    logic [DATA_WIDTH-1:0] ans;
    idu_pkg::t_div_out     n_result;
    logic                  r_valid;
    idu_pkg::t_div_out     r_result;

    always_comb begin
        mag = i_ctl.is_rem ? i_rem : i_quo;
        ans = i_ctl.neg_ans ? (~mag + 1'b1) : mag;
        if (i_ctl.dbz) begin
            ans = '0;
        end
        n_result.answer         = idu_pkg::WORD_BITS'(ans);
        n_result.divide_by_zero = i_ctl.dbz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_ctl.valid;
        end
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

[hw/rtl/int64_divide_unit.sv]
// Pipelined restoring divider, one quotient bit per stage.
// Stages: one operand stage, DATA_WIDTH step stages, one sign stage.
// Throughput: one beat per cycle; busy is low except while reset is held.
// Reset is synchronous and active low; it clears only the valid bits.
// Results appear for one cycle and cannot be held off by the receiver.
`default_nettype none

module int64_divide_unit #(
    parameter int DATA_WIDTH = idu_pkg::DATA_WIDTH_DEF
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     start,
    output logic                    busy,
    input  wire idu_pkg::t_div_in   i_operand,
    output logic                    o_valid,
    output idu_pkg::t_div_out       o_result
);

    idu_pkg::t_idu_ctl     ctl [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] rem [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] num [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] den [DATA_WIDTH+1];

    assign busy   = ~i_rst_n;
    assign rem[0] = '0;

    idu_prep #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_prep (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (start & ~busy),
        .i_operand (i_operand),
        .o_ctl     (ctl[0]),
        .o_num     (num[0]),
        .o_den     (den[0])
    );

    for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_step
        idu_step #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl[k]),
            .i_rem   (rem[k]),
            .i_num   (num[k]),
            .i_den   (den[k]),
            .o_ctl   (ctl[k+1]),
            .o_rem   (rem[k+1]),
            .o_num   (num[k+1]),
            .o_den   (den[k+1])
        );
    end

    idu_fix #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_fix (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl[DATA_WIDTH]),
        .i_rem    (rem[DATA_WIDTH]),
        .i_quo    (num[DATA_WIDTH]),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

[tb/int64_divide_unit_tb.sv]
module int64_divide_unit_tb;
    import idu_pkg::*;

    localparam int PIPE_LATENCY = 66;
    localparam int CYCLE_LIMIT  = 100000;
    localparam int GAP_PERCENT  = 37;

    localparam logic [WORD_BITS-1:0] MOST_NEG = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam logic [WORD_BITS-1:0] MOST_POS = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic [WORD_BITS-1:0] ALL_ONES = {WORD_BITS{1'b1}};

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    t_div_in    i_operand;
    logic       o_valid;
    t_div_out   o_result;

    t_div_out   pending_answers[$];
    int         error_count;
    int         cycle_count;
    bit         gaps_on;

    int64_divide_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_operand  (i_operand),
        .o_valid    (o_valid),
        .o_result   (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("int64_divide_unit_tb NOT OK");
            $finish;
        end
    end

    // Signed actions divide magnitudes and then restore the sign, so the most
    // negative value over minus one wraps back to itself without a trap.
    function automatic t_div_out predict_division(t_div_in op);
        logic [WORD_BITS-1:0] num;
        logic [WORD_BITS-1:0] den;
        logic [WORD_BITS-1:0] quo;
        logic [WORD_BITS-1:0] rem;
        logic                 num_neg;
        logic                 den_neg;
        t_div_out             res;
        res = '0;
        if (op.divisor == '0) begin
            res.divide_by_zero = 1'b1;
            return res;
        end
        num = op.dividend;
        den = op.divisor;
        num_neg = 1'b0;
        den_neg = 1'b0;
        if (op.action == ACT_SIGNED_QUO || op.action == ACT_SIGNED_REM) begin
            num_neg = num[WORD_BITS-1];
            den_neg = den[WORD_BITS-1];
            if (num_neg) num = -num;
            if (den_neg) den = -den;
        end
        quo = num / den;
        rem = num % den;
        case (op.action)
            ACT_SIGNED_QUO:   res.answer = (num_neg ^ den_neg) ? -quo : quo;
            ACT_SIGNED_REM:   res.answer = num_neg ? -rem : rem;
            ACT_UNSIGNED_QUO: res.answer = quo;
            default:          res.answer = rem;
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin : result_check
        t_div_out want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_answers.size() == 0) begin
                $display("%0t: unexpected result answer=%h divide_by_zero=%b",
                         $time, o_result.answer, o_result.divide_by_zero);
                error_count++;
            end else begin
                want = pending_answers.pop_front();
                if (o_result.answer !== want.answer) begin
                    $display("%0t: answer mismatch expected=%h actual=%h",
                             $time, want.answer, o_result.answer);
                    error_count++;
                end
                if (o_result.divide_by_zero !== want.divide_by_zero) begin
                    $display("%0t: divide_by_zero mismatch expected=%b actual=%b",
                             $time, want.divide_by_zero, o_result.divide_by_zero);
                    error_count++;
                end
            end
        end
    end

    function automatic t_div_in make_op(t_action act, logic [WORD_BITS-1:0] a,
                                        logic [WORD_BITS-1:0] b);
        t_div_in op;
        op.action   = act;
        op.dividend = a;
        op.divisor  = b;
        return op;
    endfunction

    // Mix of magnitudes so that quotients of every length show up.
    function automatic logic [WORD_BITS-1:0] random_operand();
        logic [WORD_BITS-1:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(9))
            3, 4: w = w >> $urandom_range(WORD_BITS - 1);
            5:    w = WORD_BITS'($urandom_range(15));
            6:    w = -(w >> $urandom_range(WORD_BITS - 1));
            7: begin
                case ($urandom_range(5))
                    0: w = '0;
                    1: w = 1;
                    2: w = ALL_ONES;
                    3: w = MOST_NEG;
                    4: w = MOST_POS;
                    default: w = MOST_NEG + 1;
                endcase
            end
            default: ;
        endcase
        return w;
    endfunction

    task automatic send_beat(input t_div_in op);
        while (gaps_on && $urandom_range(99) < GAP_PERCENT) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start     <= 1'b1;
        i_operand <= op;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        pending_answers.push_back(predict_division(op));
    endtask

    task automatic wait_for_answers();
        start <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_random(input int count);
        t_div_in op;
        for (int n = 0; n < count; n++) begin
            op = make_op(t_action'($urandom_range(3)), random_operand(), random_operand());
            if ($urandom_range(39) == 0) op.divisor = '0;
            send_beat(op);
        end
    endtask

    task automatic test_corner_cases();
        gaps_on = 1'b1;
        send_beat(make_op(ACT_SIGNED_QUO, 100, 7));
        send_beat(make_op(ACT_SIGNED_QUO, -64'sd100, 7));
        send_beat(make_op(ACT_SIGNED_QUO, 100, -64'sd7));
        send_beat(make_op(ACT_SIGNED_QUO, -64'sd100, -64'sd7));
        send_beat(make_op(ACT_SIGNED_REM, -64'sd100, 7));
        send_beat(make_op(ACT_SIGNED_REM, 100, -64'sd7));
        send_beat(make_op(ACT_SIGNED_REM, -64'sd1, 2));
        // The most negative value over minus one wraps; its remainder is zero.
        send_beat(make_op(ACT_SIGNED_QUO, MOST_NEG, ALL_ONES));
        send_beat(make_op(ACT_SIGNED_REM, MOST_NEG, ALL_ONES));
        send_beat(make_op(ACT_SIGNED_QUO, MOST_NEG, 1));
        send_beat(make_op(ACT_SIGNED_QUO, MOST_NEG, MOST_NEG));
        send_beat(make_op(ACT_SIGNED_QUO, MOST_POS, MOST_NEG));
        send_beat(make_op(ACT_SIGNED_REM, MOST_NEG, MOST_POS));
        send_beat(make_op(ACT_UNSIGNED_QUO, ALL_ONES, 1));
        send_beat(make_op(ACT_UNSIGNED_QUO, ALL_ONES, MOST_NEG));
        send_beat(make_op(ACT_UNSIGNED_QUO, 5, ALL_ONES));
        send_beat(make_op(ACT_UNSIGNED_REM, ALL_ONES, ALL_ONES));
        send_beat(make_op(ACT_UNSIGNED_REM, ALL_ONES, 3));
        send_beat(make_op(ACT_UNSIGNED_REM, 0, 5));
        // A zero divisor flags the result for every action.
        send_beat(make_op(ACT_SIGNED_QUO, MOST_NEG, 0));
        send_beat(make_op(ACT_SIGNED_REM, ALL_ONES, 0));
        send_beat(make_op(ACT_UNSIGNED_QUO, MOST_POS, 0));
        send_beat(make_op(ACT_UNSIGNED_REM, 12345, 0));
        send_beat(make_op(ACT_UNSIGNED_QUO, 0, 0));
    endtask

    task automatic test_random_with_gaps();
        gaps_on = 1'b1;
        send_random(350);
        // Let the pipeline empty completely before going on.
        wait_for_answers();
        send_random(350);
    endtask

    task automatic test_back_to_back();
        gaps_on = 1'b0;
        send_random(750);
    endtask

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_operand   = '0;
        error_count = 0;
        cycle_count = 0;
        gaps_on     = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_corner_cases();
        test_random_with_gaps();
        test_back_to_back();

        wait_for_answers();
        repeat (PIPE_LATENCY + 4) @(posedge i_clk);
        if (error_count == 0 && pending_answers.size() == 0) begin
            $display("int64_divide_unit_tb OK");
        end else begin
            $display("int64_divide_unit_tb NOT OK");
        end
        $finish;
    end

endmodule
